// File: hw/rtl/cbc_pkg.sv
`default_nettype none

package cbc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_TERMS = 16;

    localparam int VAL_W     = FRAC_BITS + 2;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SH_W      = VAL_W + 3;
    localparam int DIF_W     = VAL_W + 4;
    localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int COUNT_W   = 5;
    localparam int OUT_IDX_W = 4;
    localparam int NUM_STG   = MAX_TERMS - 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16);

    typedef logic signed [VAL_W-1:0] t_value;
    typedef t_value t_hist [MAX_TERMS];

    localparam t_value ONE     = t_value'(1 << FRAC_BITS);
    localparam t_value NEG_ONE = -ONE;

    // Saturates a recurrence difference to the unit interval.
    function automatic t_value clamp_unit(input logic signed [DIF_W-1:0] v);
        logic signed [DIF_W-1:0] hi;
        logic signed [DIF_W-1:0] lo;
        hi = DIF_W'(ONE);
        lo = -hi;
        if (v > hi) begin
            return ONE;
        end else if (v < lo) begin
            return NEG_ONE;
        end
        return VAL_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chebyshev_basis_clamped.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// sample    in         i_valid / o_stall  i_sample
// term      out        o_valid / i_stall  o_term_value, o_term_index, o_last_term
// config    in         i_cfg_wr_en        i_cfg_wr_data (term_count)
//
// A sample takes one input register plus MAX_TERMS-2 recurrence stages, one
// multiply, subtract and clamp each, before it reaches the output buffer.
// A new sample can enter every cycle unless the pipeline holds; the output
// port then sets the pace at N transactions per sample (N = term_count capped
// at MAX_TERMS), and a sample with N = 0 leaves the buffer with no transaction.
// Reset clears the valid bits and the output buffer's busy flag and sets term_count to 16.
// When the output buffer cannot take the next sample, the whole pipeline holds.
module chebyshev_basis_clamped (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [cbc_pkg::COUNT_W-1:0]      i_cfg_wr_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic signed [cbc_pkg::VAL_W-1:0] i_sample,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic signed [cbc_pkg::VAL_W-1:0]      o_term_value,
    output logic [cbc_pkg::OUT_IDX_W-1:0]         o_term_index,
    output logic                                  o_last_term
);

    logic [cbc_pkg::COUNT_W-1:0] r_term_count;
    logic                        r_in_valid;
    cbc_pkg::t_value             r_x;

    logic                        w_adv;
    logic                        w_ser_ready;
    logic [cbc_pkg::NUM_STG:0]   w_valid;
    cbc_pkg::t_value             w_x    [cbc_pkg::NUM_STG+1];
    cbc_pkg::t_hist              w_hist [cbc_pkg::NUM_STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= cbc_pkg::COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_term_count <= i_cfg_wr_data;
        end
    end

    assign w_adv   = !w_valid[cbc_pkg::NUM_STG] || w_ser_ready;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x <= i_sample;
        end
    end

    // History seed: T1 = x newest, T0 = 1.0 behind it.
    always_comb begin
        for (int i = 0; i < cbc_pkg::MAX_TERMS; i++) begin
            w_hist[0][i] = '0;
        end
        w_hist[0][0] = r_x;
        w_hist[0][1] = cbc_pkg::ONE;
        w_x[0]       = r_x;
        w_valid[0]   = r_in_valid;
    end

    for (genvar g = 0; g < cbc_pkg::NUM_STG; g++) begin : g_stage
        cbc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_x     (w_x[g]),
            .i_hist  (w_hist[g]),
            .o_valid (w_valid[g+1]),
            .o_x     (w_x[g+1]),
            .o_hist  (w_hist[g+1])
        );
    end

    cbc_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (w_valid[cbc_pkg::NUM_STG]),
        .i_hist       (w_hist[cbc_pkg::NUM_STG]),
        .i_count      (r_term_count),
        .o_ready      (w_ser_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_term_value (o_term_value),
        .o_term_index (o_term_index),
        .o_last_term  (o_last_term)
    );

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_term |=>
            o_valid && (o_term_index == $past(o_term_index) + 1'b1))
        else $error("term index did not advance within a sample");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_term_index >= cbc_pkg::OUT_IDX_W'(2)) |->
            (o_term_value <= cbc_pkg::ONE) && (o_term_value >= cbc_pkg::NEG_ONE))
        else $error("recurrence term outside the unit interval");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[cbc_pkg::NUM_STG] && !w_ser_ready |-> o_stall && o_valid)
        else $error("pipeline moved while the output buffer was full");

endmodule

`default_nettype wire

// File: hw/rtl/cbc_stage.sv
`default_nettype none

// One recurrence step. The newest term sits at index 0 of the history; the
// stage computes the next term from the two newest and shifts it in.
module cbc_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire cbc_pkg::t_value i_x,
    input  wire cbc_pkg::t_hist  i_hist,
    output logic                 o_valid,
    output cbc_pkg::t_value      o_x,
    output cbc_pkg::t_hist       o_hist
);

    logic signed [cbc_pkg::PROD_W-1:0] w_prod;
    logic signed [cbc_pkg::SH_W-1:0]   w_shift;
    logic signed [cbc_pkg::DIF_W-1:0]  w_diff;
    cbc_pkg::t_value                   n_term;

    logic            r_valid;
    cbc_pkg::t_value r_x;
    cbc_pkg::t_hist  r_hist;

    always_comb begin
        w_prod  = cbc_pkg::PROD_W'(i_x) * cbc_pkg::PROD_W'(i_hist[0]);
        // The factor two folds into a shift one bit shorter; >>> floors.
        w_shift = cbc_pkg::SH_W'(w_prod >>> (cbc_pkg::FRAC_BITS - 1));
        w_diff  = cbc_pkg::DIF_W'(w_shift) - cbc_pkg::DIF_W'(i_hist[1]);
        n_term  = cbc_pkg::clamp_unit(w_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x       <= i_x;
            r_hist[0] <= n_term;
            for (int i = 1; i < cbc_pkg::MAX_TERMS; i++) begin
                r_hist[i] <= i_hist[i-1];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_hist  = r_hist;

endmodule

`default_nettype wire

// File: hw/rtl/cbc_ser.sv
`default_nettype none

// Holds one sample's finished terms and hands them out one per transaction.
module cbc_ser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load_valid,
    input  wire cbc_pkg::t_hist                   i_hist,
    input  wire logic [cbc_pkg::COUNT_W-1:0]      i_count,
    output logic                                  o_ready,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output cbc_pkg::t_value                       o_term_value,
    output logic [cbc_pkg::OUT_IDX_W-1:0]         o_term_index,
    output logic                                  o_last_term
);

    logic                      r_busy;
    logic [cbc_pkg::IDX_W-1:0] r_idx;
    logic [cbc_pkg::IDX_W-1:0] r_last;
    cbc_pkg::t_hist            r_hist;

    logic                      n_busy;
    logic [cbc_pkg::IDX_W-1:0] n_idx;
    logic [cbc_pkg::IDX_W-1:0] n_last;
    logic                      w_load;
    logic                      w_at_last;
    int                        w_num;

    always_comb begin
        w_at_last = (r_idx == r_last);
        o_ready   = !r_busy || (!i_stall && w_at_last);
        w_load    = i_load_valid && o_ready;
        w_num     = (int'(i_count) > cbc_pkg::MAX_TERMS) ? cbc_pkg::MAX_TERMS : int'(i_count);

        n_busy = r_busy;
        n_idx  = r_idx;
        n_last = r_last;
        if (w_load) begin
            n_busy = (w_num != 0);
            n_idx  = '0;
            n_last = cbc_pkg::IDX_W'(w_num - 1);
        end else if (r_busy && !i_stall) begin
            if (w_at_last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_last <= n_last;
        if (w_load) begin
            r_hist <= i_hist;
        end
    end

    // The oldest term, degree zero, ends up at the top of the history.
    assign o_valid      = r_busy;
    assign o_term_value = r_hist[cbc_pkg::IDX_W'(cbc_pkg::MAX_TERMS - 1) - r_idx];
    assign o_term_index = cbc_pkg::OUT_IDX_W'(r_idx);
    assign o_last_term  = w_at_last;

endmodule

`default_nettype wire

// File: dv/chebyshev_basis_clamped_test.sv
`timescale 1ns / 1ps

module chebyshev_basis_clamped_test;

    typedef struct {
        cbc_pkg::t_value                value;
        logic [cbc_pkg::OUT_IDX_W-1:0]  index;
        logic                           last;
    } t_term;

    typedef struct {
        int count;
        int sample;
        bit typed;
        int last_val;
    } t_row;

    localparam int NUM_ROWS      = 22;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 52;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int REPORT_MAX    = 10;

    // Each row: term count, sample, whether the last term is typed in, its value.
    t_row rows [NUM_ROWS] = '{
        '{16,   65536, 1'b1,  65536},
        '{16,  -65536, 1'b1, -65536},
        '{16,       0, 1'b1,      0},
        '{16,   32768, 1'b0,      0},
        '{16,  131071, 1'b0,      0},
        '{16, -131072, 1'b0,      0},
        '{16,   98304, 1'b0,      0},
        '{16,  -98304, 1'b0,      0},
        '{16,  -65535, 1'b0,      0},
        '{16,       1, 1'b0,      0},
        '{16,      -1, 1'b0,      0},
        '{ 0,   12345, 1'b0,      0},
        '{ 0,  -65536, 1'b0,      0},
        '{ 1,   54321, 1'b1,  65536},
        '{ 1, -131072, 1'b1,  65536},
        '{ 2,  -65536, 1'b1, -65536},
        '{ 2,  131071, 1'b1, 131071},
        '{31,   65536, 1'b1,  65536},
        '{17,  -65536, 1'b1, -65536},
        '{ 3,       0, 1'b1, -65536},
        '{ 3,   65535, 1'b0,      0},
        '{16,   43690, 1'b0,      0}
    };

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [cbc_pkg::COUNT_W-1:0]   i_cfg_wr_data;
    logic                          i_valid;
    logic                          o_stall;
    cbc_pkg::t_value               i_sample;
    logic                          o_valid;
    logic                          i_stall;
    cbc_pkg::t_value               o_term_value;
    logic [cbc_pkg::OUT_IDX_W-1:0] o_term_index;
    logic                          o_last_term;

    t_term                       pending_terms [$];
    logic [cbc_pkg::COUNT_W-1:0] term_count_model;
    int                          errors;
    int                          idle_cycles;
    int                          tx_gap_max;
    int                          rx_gap_max;
    int                          hold_len;

    chebyshev_basis_clamped uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_term_value (o_term_value),
        .o_term_index (o_term_index),
        .o_last_term  (o_last_term)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Queues the basis terms one sample produces under the current term count.
    function automatic void predict_terms(input cbc_pkg::t_value x, input bit typed,
                                          input cbc_pkg::t_value typed_last);
        longint unit;
        longint xl;
        longint two_back;
        longint one_back;
        longint cur;
        int     n;
        t_term  t;
        unit     = longint'(1) <<< cbc_pkg::FRAC_BITS;
        xl       = x;
        two_back = 0;
        one_back = 0;
        n        = (term_count_model > cbc_pkg::MAX_TERMS) ? cbc_pkg::MAX_TERMS
                                                           : int'(term_count_model);
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                cur = unit;
            end else if (k == 1) begin
                cur = xl;
            end else begin
                // Arithmetic shift of the exact product floors toward minus infinity.
                cur = ((2 * xl * one_back) >>> cbc_pkg::FRAC_BITS) - two_back;
                if (cur > unit) begin
                    cur = unit;
                end else if (cur < -unit) begin
                    cur = -unit;
                end
            end
            t.value = cbc_pkg::t_value'(cur);
            t.index = cbc_pkg::OUT_IDX_W'(k);
            t.last  = (k == n - 1);
            if (typed && t.last) begin
                t.value = typed_last;
            end
            pending_terms.push_back(t);
            two_back = one_back;
            one_back = cur;
        end
    endfunction

    function automatic cbc_pkg::t_value rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return cbc_pkg::t_value'($urandom);
        end else if (pick == 1) begin
            case ($urandom_range(0, 2))
                0: return cbc_pkg::t_value'(65536);
                1: return cbc_pkg::t_value'(-65536);
                default: return cbc_pkg::t_value'(0);
            endcase
        end
        return cbc_pkg::t_value'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic send_sample(input cbc_pkg::t_value x, input bit typed,
                               input cbc_pkg::t_value typed_last);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (o_stall);
        predict_terms(x, typed, typed_last);
    endtask

    // Drains the block, lets late zero-term samples leave the pipeline, then writes.
    task automatic apply_count(input int count);
        i_valid <= 1'b0;
        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cbc_pkg::COUNT_W'(count);
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        term_count_model  = cbc_pkg::COUNT_W'(count);
    endtask

    initial begin
        int wait_cycles;
        i_stall = 1'b0;
        forever begin
            wait_cycles = $urandom_range(0, rx_gap_max);
            if (hold_len != 0) begin
                wait_cycles = hold_len;
                hold_len    = 0;
            end
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        t_term exp_term;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_terms.size() == 0) begin
                errors <= errors + 1;
                if (errors < REPORT_MAX) begin
                    $display("unexpected term: value %0d index %0d last %0b",
                             o_term_value, o_term_index, o_last_term);
                end
            end else begin
                exp_term = pending_terms.pop_front();
                if (o_term_value !== exp_term.value || o_term_index !== exp_term.index ||
                    o_last_term !== exp_term.last) begin
                    errors <= errors + 1;
                    if (errors < REPORT_MAX) begin
                        $display("expected %0d/%0d/%0b got %0d/%0d/%0b (value/index/last)",
                                 exp_term.value, exp_term.index, exp_term.last,
                                 o_term_value, o_term_index, o_last_term);
                    end
                end
            end
        end
    end

    initial begin
        t_row row;
        int   count;
        errors        = 0;
        idle_cycles   = 0;
        hold_len      = 0;
        tx_gap_max    = 17;
        rx_gap_max    = 17;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        term_count_model = cbc_pkg::COUNT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            row = rows[r];
            if (row.count != int'(term_count_model)) begin
                apply_count(row.count);
            end
            send_sample(cbc_pkg::t_value'(row.sample), row.typed,
                        cbc_pkg::t_value'(row.last_val));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: count = 16;
                1: count = 0;
                2: count = 31;
                3: count = 1;
                4: count = 2;
                5: count = 5;
                6: count = 17;
                7: count = 9;
                default: count = $urandom_range(0, 31);
            endcase
            apply_count(count);
            if (p == 0) begin
                // Back-to-back samples against a long output stall fill the pipeline.
                tx_gap_max = 0;
                rx_gap_max = 0;
                hold_len   = HOLD_CYCLES;
            end else if (p == 4) begin
                tx_gap_max = 0;
                rx_gap_max = 0;
            end else begin
                tx_gap_max = 17;
                rx_gap_max = 17;
            end
            repeat (PHASE_ITEMS) send_sample(rand_sample(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (pending_terms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
